// File: hw/rtl/gnc_pkg.sv
// Shared constants, types and codes of the grid neighbor counter.
`timescale 1ns / 1ps

package gnc_pkg;

  // Storage geometry.
  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 64;
  localparam int MAX_EXTENT = 7;

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Field widths.
  localparam int CMD_W     = 3;
  localparam int COL_W     = 6;
  localparam int ROW_W     = 6;
  localparam int EXT_W     = 3;
  localparam int CNT_W     = 8;
  localparam int SIZE_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam int GRID_SIZE_RESET = 64;

  // Coordinate arithmetic: wide enough for raw sizes, col + extent and limits.
  localparam int CRD_W = $clog2((2 ** SIZE_W) + (2 ** COL_W) + (2 ** ROW_W)
                                + MAX_EXTENT + MAX_COLS + MAX_ROWS);

  typedef logic [CRD_W-1:0] crd_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_CUR = 3'd0,
    CMD_WR_WRK = 3'd1,
    CMD_SWAP   = 3'd2,
    CMD_RD_CUR = 3'd3,
    CMD_COUNT  = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COUNT,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Effective grid size after clamping.
  typedef struct packed {
    crd_t cols;
    crd_t rows;
  } grid_size_t;

  // One request to both plane memories; read and write share the address.
  typedef struct packed {
    logic              we_a;
    logic              we_b;
    logic [ADDR_W-1:0] addr;
    logic              wdata;
  } mem_req_t;

endpackage

// File: hw/rtl/gnc_intf.sv
// Handshake channels of the grid neighbor counter: command, result and config.
`timescale 1ns / 1ps

interface gnc_in_if;
  logic                        valid;
  logic                        ready;
  logic [gnc_pkg::CMD_W-1:0]   command;
  logic [gnc_pkg::COL_W-1:0]   col;
  logic [gnc_pkg::ROW_W-1:0]   row;
  logic                        tile_value;
  logic [gnc_pkg::EXT_W-1:0]   extent;

  modport source (output valid, command, col, row, tile_value, extent, input ready);
  modport sink   (input valid, command, col, row, tile_value, extent, output ready);
endinterface

interface gnc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        read_tile;
  logic [gnc_pkg::CNT_W-1:0]   neighbor_count;

  modport source (output valid, read_tile, neighbor_count, input ready);
  modport sink   (input valid, read_tile, neighbor_count, output ready);
endinterface

interface gnc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gnc_pkg::CFG_IDX_W-1:0] index;
  logic [gnc_pkg::SIZE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/gnc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gnc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/gnc_ctrl.sv
// Command sequencer: plane clear, tile access and window scan over the planes.
`timescale 1ns / 1ps

module gnc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  gnc_in_if.sink              in_i,
  gnc_out_if.source           out_o,
  input  gnc_pkg::grid_size_t size_i,
  output gnc_pkg::mem_req_t   mem_req_o,
  input  logic                rd_a_i,
  input  logic                rd_b_i
);
  import gnc_pkg::*;

  state_e state_q, state_d;

  logic [ADDR_W-1:0] clr_q;
  logic              sel_q;
  crd_t              col_q, row_q, lo_c_q, hi_c_q, hi_r_q, c_q, r_q;
  logic              tv_q, inr_q, pend_q, res_tile_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              out_valid_q, out_tile_q;
  logic [CNT_W-1:0]  out_cnt_q;

  logic in_acc, load_out, rd_bit, last_cell, centre, hit;
  crd_t col_x, row_x, ext_x, lo_c, hi_c, lo_r, hi_r;
  logic in_range, empty, wr_cmd, to_a;

  function automatic logic [ADDR_W-1:0] addr_of(crd_t c, crd_t r);
    return ADDR_W'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  // Window bounds, clipped to the grid.
  always_comb begin
    col_x = crd_t'(in_i.col);
    row_x = crd_t'(in_i.row);
    ext_x = (crd_t'(in_i.extent) > crd_t'(MAX_EXTENT)) ? crd_t'(MAX_EXTENT)
                                                       : crd_t'(in_i.extent);
    lo_c  = (col_x > ext_x) ? col_x - ext_x : '0;
    lo_r  = (row_x > ext_x) ? row_x - ext_x : '0;
    hi_c  = (col_x + ext_x < size_i.cols - 1'b1) ? col_x + ext_x : size_i.cols - 1'b1;
    hi_r  = (row_x + ext_x < size_i.rows - 1'b1) ? row_x + ext_x : size_i.rows - 1'b1;
    empty = (lo_c > hi_c) || (lo_r > hi_r);
    in_range = (col_x < size_i.cols) && (row_x < size_i.rows);
  end

  assign in_acc    = in_i.valid && in_i.ready;
  assign rd_bit    = sel_q ? rd_b_i : rd_a_i;
  assign last_cell = (c_q == hi_c_q) && (r_q == hi_r_q);
  assign centre    = (c_q == col_q) && (r_q == row_q);
  assign hit       = pend_q && (rd_bit == tv_q) && (cnt_q != '1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == ADDR_W'(DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_i.command)
            CMD_RD_CUR: state_d = ST_READ;
            CMD_COUNT:  state_d = empty ? ST_DONE : ST_COUNT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_d = ST_DONE;
      ST_COUNT: begin
        if (last_cell) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (load_out) state_d = ST_IDLE;
      end
      default:  state_d = ST_CLEAR;
    endcase
  end

  // Outputs: handshake and memory request.
  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    load_out   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);
    wr_cmd     = in_acc && in_range
                 && ((in_i.command == CMD_WR_CUR) || (in_i.command == CMD_WR_WRK));
    // current plane is a when sel is clear; working plane is the other one
    to_a       = (in_i.command == CMD_WR_CUR) ^ sel_q;
    mem_req_o  = '0;
    mem_req_o.addr = addr_of(c_q, r_q);
    case (state_q)
      ST_CLEAR: begin
        mem_req_o.we_a = 1'b1;
        mem_req_o.we_b = 1'b1;
        mem_req_o.addr = clr_q;
      end
      ST_IDLE: begin
        mem_req_o.addr  = addr_of(col_x, row_x);
        mem_req_o.we_a  = wr_cmd && to_a;
        mem_req_o.we_b  = wr_cmd && !to_a;
        mem_req_o.wdata = in_i.tile_value;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      sel_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (in_acc && (in_i.command == CMD_SWAP)) sel_q <= !sel_q;
      // pend marks that the word now on the read port is a window cell other than the centre
      if (state_q == ST_COUNT) pend_q <= !centre;
      else                     pend_q <= 1'b0;
      if (load_out)          out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        col_q      <= col_x;
        row_q      <= row_x;
        tv_q       <= in_i.tile_value;
        inr_q      <= in_range;
        lo_c_q     <= lo_c;
        hi_c_q     <= hi_c;
        hi_r_q     <= hi_r;
        c_q        <= lo_c;
        r_q        <= lo_r;
        cnt_q      <= '0;
        res_tile_q <= 1'b0;
      end
      ST_READ: begin
        res_tile_q <= inr_q && rd_bit;
      end
      ST_COUNT: begin
        if (hit) cnt_q <= cnt_q + 1'b1;
        if (c_q == hi_c_q) begin
          c_q <= lo_c_q;
          r_q <= r_q + 1'b1;
        end else begin
          c_q <= c_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (hit) cnt_q <= cnt_q + 1'b1;
      end
      default: ;
    endcase
    if (load_out) begin
      out_tile_q <= res_tile_q;
      out_cnt_q  <= cnt_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.read_tile      = out_tile_q;
  assign out_o.neighbor_count = out_cnt_q;

  a_scan_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COUNT) |-> (c_q >= lo_c_q && c_q <= hi_c_q && r_q <= hi_r_q))
    else $error("scan position left the window");

  a_dual_write_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req_o.we_a && mem_req_o.we_b) |-> (state_q == ST_CLEAR))
    else $error("both planes written outside the clear pass");

  a_swap_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.command == CMD_SWAP) |=> (sel_q != $past(sel_q)))
    else $error("swap did not change the current plane");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (cnt_q <= CNT_W'(((2 * MAX_EXTENT + 1) ** 2) - 1)))
    else $error("count above window size");

endmodule

// File: hw/rtl/grid_neighbor_counter.sv
// Top level of the grid neighbor counter: size registers, tile planes, sequencer.
//
//   channel  dir  payload                                   handshake
//   in_i     in   command, col, row, tile_value, extent     valid/ready
//   out_o    out  read_tile, neighbor_count                 valid/ready
//   cfg_i    in   index (0 width, 1 height), data           valid/ready, always ready
//
// After reset both planes are cleared, one address a cycle, with in_i not ready
// until all MAX_COLS * MAX_ROWS addresses (4096) are written. A count scans the N
// cells of the clipped window (up to 225), one window cell per cycle, a rate set
// by the one read port of each plane memory; an empty window is not scanned.
// A held result does not block the next word in; a finished result waits in
// the final state until the output register is free.
`timescale 1ns / 1ps

module grid_neighbor_counter (
  input  logic      clk_i,
  input  logic      rst_ni,
  gnc_in_if.sink    in_i,
  gnc_out_if.source out_o,
  gnc_cfg_if.sink   cfg_i
);
  import gnc_pkg::*;

  logic [SIZE_W-1:0] width_q, height_q;
  grid_size_t        size;
  mem_req_t          mem_req;
  logic              rd_a, rd_b;
  crd_t              width_x, height_x;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(GRID_SIZE_RESET);
      height_q <= SIZE_W'(GRID_SIZE_RESET);
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_GRID_WIDTH:  width_q  <= cfg_i.data;
        REG_GRID_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // zero acts as one, anything past the limit as the limit
  always_comb begin
    width_x   = crd_t'(width_q);
    height_x  = crd_t'(height_q);
    size.cols = (width_x == '0) ? crd_t'(1)
              : (width_x > crd_t'(MAX_COLS)) ? crd_t'(MAX_COLS) : width_x;
    size.rows = (height_x == '0) ? crd_t'(1)
              : (height_x > crd_t'(MAX_ROWS)) ? crd_t'(MAX_ROWS) : height_x;
  end

  gnc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_plane_a (
    .clk_i   (clk_i),
    .we_i    (mem_req.we_a),
    .waddr_i (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.addr),
    .rdata_o (rd_a)
  );

  gnc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_plane_b (
    .clk_i   (clk_i),
    .we_i    (mem_req.we_b),
    .waddr_i (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.addr),
    .rdata_o (rd_b)
  );

  gnc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .size_i    (size),
    .mem_req_o (mem_req),
    .rd_a_i    (rd_a),
    .rd_b_i    (rd_b)
  );

endmodule

// File: tb/grid_neighbor_counter_tb.sv
// Self-checking testbench for the grid neighbor counter: directed and random traffic.
`timescale 1ns / 1ps

module grid_neighbor_counter_tb;
  import gnc_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 11;
  // writes and swaps give no word back
  localparam int LATENCY_PAD  = 300;
  // covers the plane clear after reset plus long random stalls
  localparam int QUIET_LIMIT  = 12000;

  // command codes outside the defined set: block must ignore them
  localparam logic [CMD_W-1:0]     CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0]     CMD_UNUSED_HI = 3'd7;
  // unmapped register index
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED  = 2'd3;

  typedef struct {
    logic             read_tile;
    logic [CNT_W-1:0] neighbor_count;
  } tile_result_t;

  logic clk_i;
  logic rst_ni;

  gnc_in_if  in_ch ();
  gnc_out_if out_ch ();
  gnc_cfg_if cfg_ch ();

  grid_neighbor_counter u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // shadow copy of the block state
  logic              plane_mem [2][DEPTH];
  logic              cur_plane;
  logic [SIZE_W-1:0] grid_cols_reg;
  logic [SIZE_W-1:0] grid_rows_reg;

  tile_result_t pending_results [$];
  int           error_count;
  int           send_idle_pct;
  int           stall_pct;
  int           quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  function automatic int eff_size(logic [SIZE_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic read_tile_at(int c, int r);
    if (c >= eff_size(grid_cols_reg, MAX_COLS) || r >= eff_size(grid_rows_reg, MAX_ROWS))
      return 1'b0;
    return plane_mem[cur_plane][r * MAX_COLS + c];
  endfunction

  function automatic int count_window(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                                      logic tv, logic [EXT_W-1:0] ext);
    int w, h, e, cc, rr, lo_c, hi_c, lo_r, hi_r, n;
    w  = eff_size(grid_cols_reg, MAX_COLS);
    h  = eff_size(grid_rows_reg, MAX_ROWS);
    e  = (ext > MAX_EXTENT) ? MAX_EXTENT : ext;
    cc = col;
    rr = row;
    lo_c = (cc > e) ? cc - e : 0;
    lo_r = (rr > e) ? rr - e : 0;
    hi_c = (cc + e < w - 1) ? cc + e : w - 1;
    hi_r = (rr + e < h - 1) ? rr + e : h - 1;
    n = 0;
    for (int r = lo_r; r <= hi_r; r++) begin
      for (int c = lo_c; c <= hi_c; c++) begin
        if (!(c == cc && r == rr) && read_tile_at(c, r) == tv) n++;
      end
    end
    return (n > 255) ? 255 : n;
  endfunction

  // update the shadow state for one accepted word, queue its result if any
  function automatic void apply_command(logic [CMD_W-1:0] cmd, logic [COL_W-1:0] col,
                                        logic [ROW_W-1:0] row, logic tv,
                                        logic [EXT_W-1:0] ext);
    tile_result_t res;
    int w, h;
    w = eff_size(grid_cols_reg, MAX_COLS);
    h = eff_size(grid_rows_reg, MAX_ROWS);
    case (cmd)
      CMD_WR_CUR, CMD_WR_WRK: begin
        if (col < w && row < h)
          plane_mem[(cmd == CMD_WR_CUR) ? cur_plane : !cur_plane][row * MAX_COLS + col] = tv;
      end
      CMD_SWAP: cur_plane = !cur_plane;
      CMD_RD_CUR: begin
        res.read_tile      = read_tile_at(col, row);
        res.neighbor_count = '0;
        pending_results.push_back(res);
      end
      CMD_COUNT: begin
        res.read_tile      = 1'b0;
        res.neighbor_count = CNT_W'(count_window(col, row, tv, ext));
        pending_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // enter and leave at a falling edge; valid stays high on return
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [COL_W-1:0] col,
                           logic [ROW_W-1:0] row, logic tv, logic [EXT_W-1:0] ext);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.col        <= col;
    in_ch.row        <= row;
    in_ch.tile_value <= tv;
    in_ch.extent     <= ext;
    do @(posedge clk_i); while (!in_ch.ready);
    apply_command(cmd, col, row, tv, ext);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      REG_GRID_WIDTH:  grid_cols_reg = data;
      REG_GRID_HEIGHT: grid_rows_reg = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // stop sending, wait for every result, then let trailing writes settle
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (LATENCY_PAD) @(negedge clk_i);
  endtask

  task automatic set_grid(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    drain_block();
    cfg_write(REG_GRID_WIDTH, w);
    cfg_write(REG_GRID_HEIGHT, h);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [COL_W-1:0] pick_coord(int lim);
    int p;
    p = $urandom_range(99);
    if (p < 15) return COL_W'($urandom_range(63));
    if (p < 55) return COL_W'($urandom_range(0, (lim + 1 > 63) ? 63 : lim + 1));
    return COL_W'($urandom_range(0, (lim - 1 > 9) ? 9 : lim - 1));
  endfunction

  // fresh after reset: every tile dead
  task automatic test_reset_state();
    send_word(CMD_RD_CUR, 6'd0, 6'd0, 1'b0, 3'd0);
    send_word(CMD_COUNT, 6'd0, 6'd0, 1'b0, 3'd7);
    send_word(CMD_COUNT, 6'd63, 6'd63, 1'b1, 3'd7);
  endtask

  task automatic test_plane_ops();
    send_word(CMD_WR_CUR, 6'd0, 6'd0, 1'b1, 3'd0);
    send_word(CMD_WR_CUR, 6'd63, 6'd63, 1'b1, 3'd7);
    send_word(CMD_WR_WRK, 6'd1, 6'd0, 1'b1, 3'd0);
    send_word(CMD_RD_CUR, 6'd0, 6'd0, 1'b0, 3'd0);
    send_word(CMD_RD_CUR, 6'd63, 6'd63, 1'b0, 3'd0);
    send_word(CMD_SWAP, 6'd63, 6'd63, 1'b1, 3'd7);
    send_word(CMD_RD_CUR, 6'd1, 6'd0, 1'b0, 3'd0);
    send_word(CMD_WR_WRK, 6'd63, 6'd63, 1'b0, 3'd0);
    send_word(CMD_SWAP, 6'd0, 6'd0, 1'b0, 3'd0);
    send_word(CMD_RD_CUR, 6'd63, 6'd63, 1'b0, 3'd0);
    send_word(CMD_COUNT, 6'd1, 6'd1, 1'b1, 3'd1);
    send_word(CMD_COUNT, 6'd32, 6'd32, 1'b0, 3'd7);
    send_word(CMD_COUNT, 6'd5, 6'd5, 1'b0, 3'd0);
    send_word(CMD_UNUSED_LO, 6'd63, 6'd63, 1'b1, 3'd7);
    send_word(CMD_UNUSED_HI, 6'd0, 6'd0, 1'b1, 3'd7);
    send_word(CMD_RD_CUR, 6'd0, 6'd0, 1'b0, 3'd0);
  endtask

  // clamped sizes, writes and reads off the grid, centre off the grid
  task automatic test_grid_limits();
    set_grid(7'd0, 7'd127);
    send_word(CMD_WR_CUR, 6'd1, 6'd0, 1'b1, 3'd0);
    send_word(CMD_RD_CUR, 6'd1, 6'd0, 1'b0, 3'd0);
    send_word(CMD_RD_CUR, 6'd0, 6'd63, 1'b0, 3'd0);
    send_word(CMD_COUNT, 6'd40, 6'd10, 1'b0, 3'd3);
    set_grid(7'd65, 7'd3);
    drain_block();
    cfg_write(REG_UNMAPPED, 7'd127);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
    send_word(CMD_WR_CUR, 6'd63, 6'd2, 1'b1, 3'd0);
    send_word(CMD_WR_CUR, 6'd10, 6'd3, 1'b1, 3'd0);
    send_word(CMD_COUNT, 6'd62, 6'd1, 1'b1, 3'd2);
  endtask

  task automatic random_burst(int n_items);
    logic [CMD_W-1:0] cmd;
    int w, h, p;
    w = eff_size(grid_cols_reg, MAX_COLS);
    h = eff_size(grid_rows_reg, MAX_ROWS);
    for (int i = 0; i < n_items; i++) begin
      p = $urandom_range(99);
      if (p < 35)      cmd = CMD_WR_CUR;
      else if (p < 50) cmd = CMD_WR_WRK;
      else if (p < 55) cmd = CMD_SWAP;
      else if (p < 75) cmd = CMD_RD_CUR;
      else if (p < 95) cmd = CMD_COUNT;
      else             cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      send_word(cmd, pick_coord(w), pick_coord(h), 1'($urandom_range(1)),
                EXT_W'($urandom_range(7)));
    end
  endtask

  task automatic test_random_traffic(int idle_pct, int stall, logic [SIZE_W-1:0] w,
                                     logic [SIZE_W-1:0] h, int n_items);
    set_grid(w, h);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    random_burst(n_items / 2);
    set_grid(SIZE_W'($urandom_range(1, 20)), SIZE_W'($urandom_range(1, 20)));
    random_burst(n_items - n_items / 2);
  endtask

  // receiver back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    tile_result_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word: expected none, actual tile %0d count %0d",
                 $time, out_ch.read_tile, out_ch.neighbor_count);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.read_tile !== want.read_tile) begin
          error_count++;
          $display("%0t: read_tile mismatch: expected %0d actual %0d",
                   $time, want.read_tile, out_ch.read_tile);
        end
        if (out_ch.neighbor_count !== want.neighbor_count) begin
          error_count++;
          $display("%0t: neighbor_count mismatch: expected %0d actual %0d",
                   $time, want.neighbor_count, out_ch.neighbor_count);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("grid_neighbor_counter_tb: done, errors");
      $finish;
    end
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.command    = '0;
    in_ch.col        = '0;
    in_ch.row        = '0;
    in_ch.tile_value = 1'b0;
    in_ch.extent     = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    rst_ni           = 1'b0;
    error_count      = 0;
    quiet_cycles     = 0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    cur_plane        = 1'b0;
    grid_cols_reg    = SIZE_W'(GRID_SIZE_RESET);
    grid_rows_reg    = SIZE_W'(GRID_SIZE_RESET);
    for (int i = 0; i < DEPTH; i++) begin
      plane_mem[0][i] = 1'b0;
      plane_mem[1][i] = 1'b0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_plane_ops();
    test_grid_limits();
    test_random_traffic(0, 0, 7'd6, 7'd4, 130);
    test_random_traffic(46, 0, 7'd64, 7'd64, 130);
    test_random_traffic(0, 46, 7'd1, 7'd1, 130);
    test_random_traffic(36, 36, 7'd127, 7'd9, 130);

    drain_block();
    if (error_count == 0 && pending_results.size() == 0)
      $display("grid_neighbor_counter_tb: done, clean");
    else
      $display("grid_neighbor_counter_tb: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/gnc_pkg.sv
hw/rtl/gnc_intf.sv
hw/rtl/gnc_ram.sv
hw/rtl/gnc_ctrl.sv
hw/rtl/grid_neighbor_counter.sv
tb/grid_neighbor_counter_tb.sv
